>>> rtl/spimbs_pkg.sv
`default_nettype none

package spimbs_pkg;

  // Default frame length and divider width.
  localparam int FRAME_BITS_DEF    = 8;
  localparam int DIVIDER_WIDTH_DEF = 8;

  // Widths fixed by the item fields and the register file.
  localparam int BYTE_W  = 8;
  localparam int MODE_W  = 2;
  localparam int HPT_W   = 8;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 2;

  // Register indexes (byte address is four times the index).
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SPI_MODE  = 2'd0,
    REG_BIT_ORDER = 2'd1,
    REG_HALF_PER  = 2'd2
  } reg_idx_t;

  // Request codes carried in req_type.
  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_START = 1'b1
  } req_t;

endpackage

`default_nettype wire

>>> rtl/spi_master_byte_shifter_top.sv
`default_nettype none

// SPI master byte shifter, modes 0 to 3, full duplex.
// Input channel (in_valid/in_ready): each request is either a time tick carrying
// the MISO level or a start request carrying the byte to send. Every accepted
// request produces exactly one result on the output channel (out_valid/out_ready)
// with the SCK and MOSI levels, busy, done and the received byte.
// The shifter state and the result register are both updated at the edge that
// accepts the request. Throughput is one request per clock while out_ready is
// high, set by the single register stage between input and result.
// When the receiver stalls, the result register holds its contents and the block
// accepts a new request only in the cycle in which the waiting result is taken,
// so a full stall blocks the input after one result.
// Reset (synchronous, active high) clears the shifter to idle in mode 0, MSB
// first, a divider limit of zero, and empties the result register.
// Registers via the APB port: spi_mode at 0x0, the bit order at 0x4,
// half_period_ticks at 0x8. Write them only while no transfer is running.
module spi_master_byte_shifter_top #(
  parameter int FRAME_BITS    = spimbs_pkg::FRAME_BITS_DEF,
  parameter int DIVIDER_WIDTH = spimbs_pkg::DIVIDER_WIDTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  // input channel
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             req_type,
  input  wire  [spimbs_pkg::BYTE_W-1:0]   tx_byte,
  input  wire                             miso,
  // output channel
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic                            sck,
  output logic                            mosi,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [spimbs_pkg::BYTE_W-1:0]   rx_byte,
  // configuration port
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [spimbs_pkg::PADDR_W-1:0]  paddr,
  input  wire  [spimbs_pkg::PDATA_W-1:0]  pwdata,
  output logic [spimbs_pkg::PDATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int BW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam logic [BW-1:0] LAST_BIT = BW'(FRAME_BITS - 1);

  // Configuration registers
  logic [spimbs_pkg::MODE_W-1:0] spi_mode;
  logic                          lsb_lead;
  logic [spimbs_pkg::HPT_W-1:0]  half_period_ticks;

  // Shifter state
  logic [FRAME_BITS-1:0]    tx_shift, tx_shift_next;
  logic [FRAME_BITS-1:0]    rx_shift, rx_shift_next;
  logic [BW-1:0]            bits_done, bits_done_next;
  logic                     second_half, second_half_next;
  logic [DIVIDER_WIDTH-1:0] tick_count, tick_count_next;
  logic                     active, active_next;
  logic                     clock_level, clock_level_next;
  logic                     data_out_level, data_out_level_next;
  logic                     done_next;
  logic [spimbs_pkg::BYTE_W-1:0] rx_out_next;

  logic                     in_accept;
  logic                     cfg_write;
  spimbs_pkg::reg_idx_t     reg_idx;
  logic                     cpol, cpha;
  logic [DIVIDER_WIDTH-1:0] limit;
  logic [FRAME_BITS+spimbs_pkg::BYTE_W-1:0] tx_ext;
  logic [FRAME_BITS+spimbs_pkg::BYTE_W-1:0] rx_ext;
  logic [DIVIDER_WIDTH+spimbs_pkg::HPT_W-1:0] hpt_ext;
  logic [BW-1:0]            pos_cur, pos_start, pos_nxt;

  function automatic logic [BW-1:0] bit_pos(input logic lsb, input logic [BW-1:0] n);
    return lsb ? n : (LAST_BIT - n);
  endfunction

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = spimbs_pkg::reg_idx_t'(paddr[spimbs_pkg::PADDR_W-1:2]);

  assign cpol    = spi_mode[1];
  assign cpha    = spi_mode[0];
  assign hpt_ext = {{DIVIDER_WIDTH{1'b0}}, half_period_ticks};
  assign limit   = hpt_ext[DIVIDER_WIDTH-1:0];
  assign tx_ext  = {{FRAME_BITS{1'b0}}, tx_byte};

  // The received byte is the low part of the frame after the last sample.
  assign rx_ext      = {{spimbs_pkg::BYTE_W{1'b0}}, rx_shift_next};
  assign rx_out_next = done_next ? rx_ext[spimbs_pkg::BYTE_W-1:0] : '0;

  assign pos_cur   = bit_pos(lsb_lead, bits_done);
  assign pos_nxt   = bit_pos(lsb_lead, bits_done + BW'(1));
  assign pos_start = bit_pos(lsb_lead, '0);

  // One step of the shifter for the request at the input.
  always_comb begin
    tx_shift_next       = tx_shift;
    rx_shift_next       = rx_shift;
    bits_done_next      = bits_done;
    second_half_next    = second_half;
    tick_count_next     = tick_count;
    active_next         = active;
    clock_level_next    = clock_level;
    data_out_level_next = data_out_level;
    done_next           = 1'b0;
    if (!active) begin
      clock_level_next = cpol;
      if (spimbs_pkg::req_t'(req_type) == spimbs_pkg::REQ_START) begin
        tx_shift_next    = tx_ext[FRAME_BITS-1:0];
        rx_shift_next    = '0;
        bits_done_next   = '0;
        second_half_next = 1'b0;
        tick_count_next  = '0;
        active_next      = 1'b1;
        if (!cpha) begin
          data_out_level_next = tx_ext[pos_start];
        end
      end
    end else if (tick_count < limit) begin
      tick_count_next = tick_count + DIVIDER_WIDTH'(1);
    end else begin
      tick_count_next = '0;
      if (!second_half) begin
        // Leading edge.
        clock_level_next = !cpol;
        if (cpha) begin
          data_out_level_next = tx_shift[pos_cur];
        end else begin
          rx_shift_next[pos_cur] = miso;
        end
        second_half_next = 1'b1;
      end else begin
        // Trailing edge.
        clock_level_next = cpol;
        if (cpha) begin
          rx_shift_next[pos_cur] = miso;
        end
        second_half_next = 1'b0;
        if (bits_done == LAST_BIT) begin
          active_next    = 1'b0;
          done_next      = 1'b1;
          bits_done_next = '0;
        end else begin
          bits_done_next = bits_done + BW'(1);
          if (!cpha) begin
            data_out_level_next = tx_shift[pos_nxt];
          end
        end
      end
    end
  end

  // Configuration registers and shifter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      spi_mode          <= '0;
      lsb_lead          <= 1'b0;
      half_period_ticks <= '0;
      tx_shift          <= '0;
      rx_shift          <= '0;
      bits_done         <= '0;
      second_half       <= 1'b0;
      tick_count        <= '0;
      active            <= 1'b0;
      clock_level       <= 1'b0;
      data_out_level    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_idx)
          spimbs_pkg::REG_SPI_MODE:  spi_mode <= pwdata[spimbs_pkg::MODE_W-1:0];
          spimbs_pkg::REG_BIT_ORDER: lsb_lead <= pwdata[0];
          spimbs_pkg::REG_HALF_PER:  half_period_ticks <= pwdata[spimbs_pkg::HPT_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        tx_shift       <= tx_shift_next;
        rx_shift       <= rx_shift_next;
        bits_done      <= bits_done_next;
        second_half    <= second_half_next;
        tick_count     <= tick_count_next;
        active         <= active_next;
        clock_level    <= clock_level_next;
        data_out_level <= data_out_level_next;
      end else if (cfg_write && reg_idx == spimbs_pkg::REG_SPI_MODE && !active) begin
        // The idle clock level follows a new polarity at once.
        clock_level <= pwdata[1];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sck      <= clock_level_next;
      mosi     <= data_out_level_next;
      busy_res <= active_next;
      done_res <= done_next;
      rx_byte  <= rx_out_next;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      spimbs_pkg::REG_SPI_MODE:  prdata[spimbs_pkg::MODE_W-1:0] = spi_mode;
      spimbs_pkg::REG_BIT_ORDER: prdata[0] = lsb_lead;
      spimbs_pkg::REG_HALF_PER:  prdata[spimbs_pkg::HPT_W-1:0] = half_period_ticks;
      default: prdata = '0;
    endcase
  end

  // Checks
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while transfer still busy");

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (rst)
    !active |-> bits_done == '0 && !second_half)
    else $error("bit counter or half flag left set while idle");

  a_start_goes_active: assert property (@(posedge clk) disable iff (rst)
    in_accept && !active && req_type == spimbs_pkg::REQ_START |=> active && busy_res)
    else $error("start request did not begin a transfer");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted request produced no result");

endmodule

`default_nettype wire

>>> test/spi_master_byte_shifter_top_test.sv
`timescale 1ns / 100ps

module spi_master_byte_shifter_top_test;

  localparam int FRAME_LEN   = spimbs_pkg::FRAME_BITS_DEF;
  localparam int GAP_PCT     = 18;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic                          sck;
    logic                          mosi;
    logic                          busy;
    logic                          done;
    logic [spimbs_pkg::BYTE_W-1:0] rx;
  } line_state_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic                           req_type;
  logic [spimbs_pkg::BYTE_W-1:0]  tx_byte;
  logic                           miso;
  logic                           out_valid;
  logic                           out_ready;
  logic                           sck;
  logic                           mosi;
  logic                           busy_res;
  logic                           done_res;
  logic [spimbs_pkg::BYTE_W-1:0]  rx_byte;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [spimbs_pkg::PADDR_W-1:0] paddr;
  logic [spimbs_pkg::PDATA_W-1:0] pwdata;
  logic [spimbs_pkg::PDATA_W-1:0] prdata;
  logic                           pready;

  // Configuration and shifter state as the predictor sees them.
  logic [spimbs_pkg::MODE_W-1:0]  cfg_mode;
  logic                           cfg_lsb_lead;
  logic [spimbs_pkg::HPT_W-1:0]   cfg_half_ticks;
  logic [spimbs_pkg::BYTE_W-1:0]  shadow_tx;
  logic [spimbs_pkg::BYTE_W-1:0]  shadow_rx;
  logic [3:0]                     shadow_bits;
  logic                           shadow_high_half;
  logic [spimbs_pkg::HPT_W-1:0]   shadow_ticks;
  logic                           shadow_busy;
  logic                           shadow_sck;
  logic                           shadow_mosi;

  line_state_t expected_lines[$];
  bit          steady;
  int          mismatch_count;
  int          requests_sent;
  int          frames_predicted;
  int          settings_used;
  int          stall_cycles;

  spi_master_byte_shifter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .tx_byte   (tx_byte),
    .miso      (miso),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sck       (sck),
    .mosi      (mosi),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .rx_byte   (rx_byte),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int frame_bit_index(logic [3:0] n);
    return cfg_lsb_lead ? int'(n) : FRAME_LEN - 1 - int'(n);
  endfunction

  // Advances the shifter by one request and returns the line state it leaves.
  function automatic line_state_t advance_shifter(spimbs_pkg::req_t kind,
                                                  logic [spimbs_pkg::BYTE_W-1:0] tx,
                                                  logic miso_level);
    line_state_t res;
    logic        cpol;
    logic        cpha;
    cpol = cfg_mode[1];
    cpha = cfg_mode[0];
    res.done = 1'b0;
    res.rx = '0;
    if (!shadow_busy) begin
      shadow_sck = cpol;
      if (kind == spimbs_pkg::REQ_START) begin
        shadow_tx = tx;
        shadow_rx = '0;
        shadow_bits = '0;
        shadow_high_half = 1'b0;
        shadow_ticks = '0;
        shadow_busy = 1'b1;
        if (!cpha) shadow_mosi = shadow_tx[frame_bit_index(4'd0)];
      end
    end else if (shadow_ticks < cfg_half_ticks) begin
      shadow_ticks = shadow_ticks + 1'b1;
    end else begin
      shadow_ticks = '0;
      if (!shadow_high_half) begin
        shadow_sck = ~cpol;
        if (cpha) shadow_mosi = shadow_tx[frame_bit_index(shadow_bits)];
        else shadow_rx[frame_bit_index(shadow_bits)] = miso_level;
        shadow_high_half = 1'b1;
      end else begin
        shadow_sck = cpol;
        if (cpha) shadow_rx[frame_bit_index(shadow_bits)] = miso_level;
        shadow_high_half = 1'b0;
        shadow_bits = shadow_bits + 1'b1;
        if (shadow_bits >= FRAME_LEN) begin
          shadow_busy = 1'b0;
          res.done = 1'b1;
          res.rx = shadow_rx;
          shadow_bits = '0;
          frames_predicted++;
        end else if (!cpha) begin
          shadow_mosi = shadow_tx[frame_bit_index(shadow_bits)];
        end
      end
    end
    res.sck = shadow_sck;
    res.mosi = shadow_mosi;
    res.busy = shadow_busy;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin : result_check
    line_state_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          report_mismatch("unrequested result rx_byte", rx_byte, 0);
        end else begin
          want = expected_lines.pop_front();
          if (sck !== want.sck) report_mismatch("sck", sck, want.sck);
          if (mosi !== want.mosi) report_mismatch("mosi", mosi, want.mosi);
          if (busy_res !== want.busy) report_mismatch("busy_res", busy_res, want.busy);
          if (done_res !== want.done) report_mismatch("done_res", done_res, want.done);
          if (rx_byte !== want.rx) report_mismatch("rx_byte", rx_byte, want.rx);
        end
      end
      out_ready <= steady || ($urandom_range(99) >= GAP_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("spi_master_byte_shifter_top_test: done, errors");
    $finish;
  end

  task automatic send_request(spimbs_pkg::req_t kind, logic [spimbs_pkg::BYTE_W-1:0] tx,
                              logic miso_level);
    while (!steady && $urandom_range(99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    req_type <= kind;
    tx_byte <= tx;
    miso <= miso_level;
    in_valid <= 1'b1;
    expected_lines.push_back(advance_shifter(kind, tx, miso_level));
    requests_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_tick();
    send_request(spimbs_pkg::REQ_TICK, spimbs_pkg::BYTE_W'($urandom_range(255)),
                 1'($urandom_range(1)));
  endtask

  task automatic finish_frame();
    while (shadow_busy) send_tick();
  endtask

  // Stops sending and waits until every outstanding request has its result.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_lines.size() != 0);
  endtask

  task automatic write_register(spimbs_pkg::reg_idx_t idx,
                                logic [spimbs_pkg::PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      spimbs_pkg::REG_SPI_MODE: begin
        cfg_mode = value[spimbs_pkg::MODE_W-1:0];
        if (!shadow_busy) shadow_sck = cfg_mode[1];
      end
      spimbs_pkg::REG_BIT_ORDER: cfg_lsb_lead = value[0];
      spimbs_pkg::REG_HALF_PER: cfg_half_ticks = value[spimbs_pkg::HPT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Registers change only with no frame running and nothing outstanding.
  task automatic apply_setting(logic [spimbs_pkg::MODE_W-1:0] mode, logic lsb,
                               logic [spimbs_pkg::HPT_W-1:0] half);
    finish_frame();
    settle();
    write_register(spimbs_pkg::REG_SPI_MODE, spimbs_pkg::PDATA_W'(mode));
    write_register(spimbs_pkg::REG_BIT_ORDER, spimbs_pkg::PDATA_W'(lsb));
    write_register(spimbs_pkg::REG_HALF_PER, spimbs_pkg::PDATA_W'(half));
    settings_used++;
  endtask

  // Mostly complete frames with random data; some ticks while idle and some
  // start requests that land in the middle of a frame.
  task automatic random_traffic(int count);
    for (int k = 0; k < count; k++) begin
      if (!shadow_busy && $urandom_range(99) < 75) begin
        send_request(spimbs_pkg::REQ_START, spimbs_pkg::BYTE_W'($urandom_range(255)),
                     1'($urandom_range(1)));
      end else if (shadow_busy && $urandom_range(99) < 4) begin
        send_request(spimbs_pkg::REQ_START, spimbs_pkg::BYTE_W'($urandom_range(255)),
                     1'($urandom_range(1)));
      end else begin
        send_tick();
      end
      if ($urandom_range(199) == 0) settle();
    end
  endtask

  task automatic test_idle_lines();
    apply_setting(2'd0, 1'b0, 8'd0);
    send_request(spimbs_pkg::REQ_TICK, 8'h00, 1'b0);
    send_request(spimbs_pkg::REQ_TICK, 8'hFF, 1'b1);
    settle();
    write_register(spimbs_pkg::REG_SPI_MODE, spimbs_pkg::PDATA_W'(2'd2));
    send_request(spimbs_pkg::REQ_TICK, 8'h00, 1'b1);
    settle();
    write_register(spimbs_pkg::REG_SPI_MODE, spimbs_pkg::PDATA_W'(2'd1));
    send_request(spimbs_pkg::REQ_TICK, 8'hFF, 1'b0);
  endtask

  task automatic test_directed_frames();
    int n;
    apply_setting(2'd0, 1'b0, 8'd0);
    send_request(spimbs_pkg::REQ_START, 8'hFF, 1'b1);
    while (shadow_busy) send_request(spimbs_pkg::REQ_TICK, 8'h00, 1'b1);
    apply_setting(2'd3, 1'b1, 8'd0);
    send_request(spimbs_pkg::REQ_START, 8'h00, 1'b0);
    n = 0;
    while (shadow_busy) begin
      // A start request in the middle of the frame must be ignored.
      if (n == 5) send_request(spimbs_pkg::REQ_START, 8'hFF, 1'b1);
      else send_request(spimbs_pkg::REQ_TICK, 8'h00, 1'(n));
      n++;
    end
    apply_setting(2'd1, 1'b0, 8'd1);
    send_request(spimbs_pkg::REQ_START, 8'h5A, 1'b0);
    settle();
    while (shadow_busy) send_request(spimbs_pkg::REQ_TICK, 8'h00, 1'b0);
  endtask

  task automatic test_random_settings();
    for (int c = 0; c < 8; c++) begin
      apply_setting(spimbs_pkg::MODE_W'(c), 1'(c >> 2),
                    (c < 2) ? 8'd0 : spimbs_pkg::HPT_W'($urandom_range(3)));
      random_traffic(100);
    end
  endtask

  task automatic test_slowest_divider();
    apply_setting(spimbs_pkg::MODE_W'($urandom_range(3)), 1'($urandom_range(1)), 8'd47);
    send_request(spimbs_pkg::REQ_START, spimbs_pkg::BYTE_W'($urandom_range(255)),
                 1'($urandom_range(1)));
    finish_frame();
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    apply_setting(spimbs_pkg::MODE_W'($urandom_range(3)), 1'($urandom_range(1)), 8'd0);
    random_traffic(200);
    steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= spimbs_pkg::REQ_TICK;
    tx_byte <= '0;
    miso <= 1'b0;
    out_ready <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady = 1'b0;
    mismatch_count = 0;
    requests_sent = 0;
    frames_predicted = 0;
    settings_used = 0;
    cfg_mode = '0;
    cfg_lsb_lead = 1'b0;
    cfg_half_ticks = '0;
    shadow_tx = '0;
    shadow_rx = '0;
    shadow_bits = '0;
    shadow_high_half = 1'b0;
    shadow_ticks = '0;
    shadow_busy = 1'b0;
    shadow_sck = 1'b0;
    shadow_mosi = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_lines();
    test_directed_frames();
    test_random_settings();
    test_slowest_divider();
    test_back_to_back();
    apply_setting(2'd2, 1'b1, 8'd2);
    random_traffic(100);

    finish_frame();
    settle();
    repeat (5) @(posedge clk);
    $display("Sent %0d requests, %0d frames completed under %0d register settings,",
             requests_sent, frames_predicted, settings_used);
    $display("covering all four modes, both bit orders and dividers from 0 to 47.");
    if (mismatch_count == 0) begin
      $display("spi_master_byte_shifter_top_test: done, clean");
    end else begin
      $display("spi_master_byte_shifter_top_test: done, errors");
    end
    $finish;
  end

endmodule
